>>> rtl/spmr_pkg.sv
// Package with the widths, register codes and constants of the stereo range pipeline.
`default_nettype none

package spmr_pkg;

  localparam int unsigned PointW = 24;
  localparam int unsigned LaneW  = 21;
  localparam int unsigned RegW   = 63;
  localparam int unsigned IdxW   = 3;
  localparam int unsigned RangeW = 26;

  // Register indexes on the write port.
  localparam logic [IdxW-1:0] REG_ROT0  = 3'd0;
  localparam logic [IdxW-1:0] REG_ROT1  = 3'd1;
  localparam logic [IdxW-1:0] REG_ROT2  = 3'd2;
  localparam logic [IdxW-1:0] REG_TRANS = 3'd3;

  localparam logic [RegW-1:0] ROT0_RESET  = 63'd524288;
  localparam logic [RegW-1:0] ROT1_RESET  = 63'd1099511627776;
  localparam logic [RegW-1:0] ROT2_RESET  = 63'd2305843009213693952;
  localparam logic [RegW-1:0] TRANS_RESET = 63'd0;

  localparam int unsigned SqrtSteps = 32;

  // Root values at or above this give a range beyond the output field.
  localparam logic [31:0] SAT_ROOT = 32'd524288000;

  // floor(2^40 / 125): 16 * s / 125 is s * RECIP >> 36, give or take one.
  localparam logic [33:0] RECIP    = 34'd8796093022;
  localparam logic [16:0] RECIP_LO = RECIP[16:0];
  localparam logic [16:0] RECIP_HI = RECIP[33:17];
  localparam logic [34:0] DIVISOR  = 35'd125;

  localparam logic [RangeW-1:0] RANGE_MAX = 26'd67108863;

  // Cycles from an accepted point to its result strobe.
  localparam int unsigned Latency = 39;

endpackage

`default_nettype wire

>>> rtl/stereo_point_median_range.sv
// Top level of the stereo point range pipeline: rotation, distances, root and scaling.
`default_nettype none

// Takes one point per clock and never stalls: busy_o is high only during reset.
// Each result comes out on done_o in order; the pipeline depth is set mostly by
// the 32-step square root pipeline, with three stages for the rotation and
// distances and three for the scaling to meters. Configuration writes take
// effect at once and belong between points.
module stereo_point_median_range
  import spmr_pkg::*;
(
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       start_i,
  output logic                      busy_o,
  input  wire  signed [PointW-1:0]  point_x_i,
  input  wire  signed [PointW-1:0]  point_y_i,
  input  wire  signed [PointW-1:0]  point_z_i,
  input  wire                       cfg_we_i,
  input  wire         [IdxW-1:0]    cfg_idx_i,
  input  wire         [RegW-1:0]    cfg_wdata_i,
  output logic                      done_o,
  output logic        [RangeW-1:0]  range_meters_o,
  output logic                      range_saturated_o
);

  logic [RegW-1:0] rot_q [3];
  logic [RegW-1:0] trans_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q[0] <= ROT0_RESET;
      rot_q[1] <= ROT1_RESET;
      rot_q[2] <= ROT2_RESET;
      trans_q  <= TRANS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ROT0:  rot_q[0] <= cfg_wdata_i;
        REG_ROT1:  rot_q[1] <= cfg_wdata_i;
        REG_ROT2:  rot_q[2] <= cfg_wdata_i;
        REG_TRANS: trans_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic signed [LaneW-1:0]  coef [3][3];
  logic signed [LaneW-1:0]  tvec [3];
  logic signed [PointW-1:0] pin  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        coef[i][j] = rot_q[i][j*LaneW +: LaneW];
      end
      tvec[i] = trans_q[i*LaneW +: LaneW];
    end
    pin[0] = point_x_i;
    pin[1] = point_y_i;
    pin[2] = point_z_i;
  end

  assign busy_o = ~rst_ni;

  logic accept;
  assign accept = start_i & ~busy_o;

  // Stage 1: all products.
  logic               v1_q;
  logic signed [44:0] rp_q [3][3];
  logic signed [47:0] pp_q [3];
  logic signed [41:0] tt_q [3];
  logic signed [LaneW-1:0] t1_q [3];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        rp_q[i][j] <= coef[i][j] * pin[j];
      end
      pp_q[i] <= pin[i] * pin[i];
      tt_q[i] <= tvec[i] * tvec[i];
      t1_q[i] <= tvec[i];
    end
  end

  // Stage 2: rotated point, rounded to 1/16 mm, plus translation, and the sums of squares of point and translation.
  logic               v2_q;
  logic signed [27:0] q2_q [3];
  logic signed [49:0] dl2_d, dl2_q;
  logic signed [43:0] dt2_d, dt2_q;
  logic signed [27:0] q2_d [3];
  logic signed [47:0] acc  [3];
  logic signed [47:0] qsum [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i]  = 48'(rp_q[i][0]) + 48'(rp_q[i][1]) + 48'(rp_q[i][2]) + 48'sd262144;
      qsum[i] = (acc[i] >>> 19) + 48'(t1_q[i]);
      q2_d[i] = qsum[i][27:0];
    end
    dl2_d = 50'(pp_q[0]) + 50'(pp_q[1]) + 50'(pp_q[2]);
    dt2_d = 44'(tt_q[0]) + 44'(tt_q[1]) + 44'(tt_q[2]);
  end

  always_ff @(posedge clk_i) begin
    q2_q  <= q2_d;
    dl2_q <= dl2_d;
    dt2_q <= dt2_d;
  end

  // Stage 3: squares of the rotated point.
  logic               v3_q;
  logic signed [55:0] qq_q [3];
  logic signed [49:0] dl3_q;
  logic signed [43:0] dt3_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      qq_q[i] <= q2_q[i] * q2_q[i];
    end
    dl3_q <= dl2_q;
    dt3_q <= dt2_q;
  end

  // Stage 4: radicand, clamped at zero and scaled by 256 for four fraction bits.
  logic signed [59:0] rad;
  logic        [63:0] rad_n;

  always_comb begin
    rad = 60'(qq_q[0]) + 60'(qq_q[1]) + 60'(qq_q[2]);
    rad = (rad <<< 1) + (60'(dl3_q) <<< 1) - 60'(dt3_q);
    if (rad < 0) begin
      rad_n = '0;
    end else begin
      rad_n = 64'(rad[55:0]) << 8;
    end
  end

  logic        sq_vld_q [SqrtSteps+1];
  logic [63:0] sq_rem_q [SqrtSteps+1];
  logic [63:0] sq_res_q [SqrtSteps+1];

  always_ff @(posedge clk_i) begin
    sq_rem_q[0] <= rad_n;
    sq_res_q[0] <= '0;
  end

  // One root step per stage, two radicand bits each.
  for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
    localparam logic [63:0] StepBit = 64'd1 << (62 - 2*k);
    logic [64:0] trial;
    assign trial = 65'(sq_res_q[k]) + 65'(StepBit);

    always_ff @(posedge clk_i) begin
      if ({1'b0, sq_rem_q[k]} >= trial) begin
        sq_rem_q[k+1] <= sq_rem_q[k] - trial[63:0];
        sq_res_q[k+1] <= (sq_res_q[k] >> 1) + StepBit;
      end else begin
        sq_rem_q[k+1] <= sq_rem_q[k];
        sq_res_q[k+1] <= sq_res_q[k] >> 1;
      end
    end
  end

  // Stage A: overflow check and the two halves of the reciprocal product.
  logic        [31:0] root;
  logic               v37_q, sat37_q;
  logic        [28:0] s37_q;
  logic        [45:0] plo_q, phi_q;

  assign root = sq_res_q[SqrtSteps][31:0];

  always_ff @(posedge clk_i) begin
    sat37_q <= (root >= SAT_ROOT);
    s37_q   <= root[28:0];
    plo_q   <= root[28:0] * RECIP_LO;
    phi_q   <= root[28:0] * RECIP_HI;
  end

  // Stage B: quotient estimate, at most one below the exact value.
  logic               v38_q, sat38_q;
  logic        [28:0] s38_q;
  logic        [26:0] q38_q;
  logic        [63:0] psum;

  assign psum = (64'(phi_q) << 17) + 64'(plo_q);

  always_ff @(posedge clk_i) begin
    sat38_q <= sat37_q;
    s38_q   <= s37_q;
    q38_q   <= psum[62:36];
  end

  // Stage C: correction and saturation into the output registers.
  logic        [34:0] rem;
  logic        [26:0] q_fix;
  logic        [RangeW-1:0] range_d;

  always_comb begin
    rem   = 35'({s38_q, 4'b0000}) - 35'(q38_q) * DIVISOR;
    q_fix = (rem >= DIVISOR) ? q38_q + 27'd1 : q38_q;
    range_d = sat38_q ? RANGE_MAX : q_fix[RangeW-1:0];
  end

  logic              done_q, sat_q;
  logic [RangeW-1:0] range_q;

  always_ff @(posedge clk_i) begin
    range_q <= range_d;
    sat_q   <= sat38_q;
  end

  // Valid bits for every stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      for (int k = 0; k <= SqrtSteps; k++) begin
        sq_vld_q[k] <= 1'b0;
      end
      v37_q  <= 1'b0;
      v38_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q        <= accept;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      sq_vld_q[0] <= v3_q;
      for (int k = 0; k < SqrtSteps; k++) begin
        sq_vld_q[k+1] <= sq_vld_q[k];
      end
      v37_q  <= sq_vld_q[SqrtSteps];
      v38_q  <= v37_q;
      done_q <= v38_q;
    end
  end

  assign done_o            = done_q;
  assign range_meters_o    = range_q;
  assign range_saturated_o = sat_q;

endmodule

`default_nettype wire

>>> rtl/spmr_checker.sv
// Port-level checker for the stereo point range pipeline, bound to the top level.
`default_nettype none

module spmr_checker
  import spmr_pkg::*;
(
  input wire                clk_i,
  input wire                rst_ni,
  input wire                start_i,
  input wire                busy_o,
  input wire                done_o,
  input wire [RangeW-1:0]   range_meters_o,
  input wire                range_saturated_o
);

  // Every accepted transaction yields one result after the fixed latency.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##Latency done_o)
    else $error("accepted transaction gave no result on time");

  // No result appears without a transaction taken the latency before.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, Latency))
    else $error("result without a matching transaction");

  // A saturated result carries the largest range.
  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && range_saturated_o) |-> (range_meters_o == RANGE_MAX))
    else $error("saturated result is not clamped");

endmodule

bind stereo_point_median_range spmr_checker u_spmr_checker (.*);

`default_nettype wire

>>> dv/stereo_point_median_range_test.sv
// Testbench for the stereo point range pipeline, with its own range predictor.
`timescale 1ns / 100ps

module stereo_point_median_range_test;
  import spmr_pkg::*;

  typedef struct packed {
    logic [RangeW-1:0] meters;
    logic              sat;
  } range_t;

  localparam int CoordMax = 8388607;
  localparam int CoordMin = -8388608;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     start_i;
  logic                     busy_o;
  logic signed [PointW-1:0] point_x_i;
  logic signed [PointW-1:0] point_y_i;
  logic signed [PointW-1:0] point_z_i;
  logic                     cfg_we_i;
  logic [IdxW-1:0]          cfg_idx_i;
  logic [RegW-1:0]          cfg_wdata_i;
  logic                     done_o;
  logic [RangeW-1:0]        range_meters_o;
  logic                     range_saturated_o;

  // Local copy of the four registers.
  logic [RegW-1:0] rot_rows [3];
  logic [RegW-1:0] trans_word;

  range_t expected_ranges [$];
  int     mismatches;
  bit     gaps_on;

  stereo_point_median_range uut (
    .clk_i, .rst_ni, .start_i, .busy_o, .point_x_i, .point_y_i, .point_z_i,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i, .done_o, .range_meters_o,
    .range_saturated_o
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("stereo_point_median_range_test: errors");
    $finish;
  end

  function automatic longint lane(logic [RegW-1:0] word, int k);
    logic signed [LaneW-1:0] v;
    v = word[LaneW*k +: LaneW];
    return longint'(v);
  endfunction

  function automatic longint unsigned int_root(longint unsigned n);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic range_t median_range(longint px, longint py, longint pz);
    longint p [3];
    longint q [3];
    longint t [3];
    longint acc, dl2, dr2, dt2, rad;
    longint unsigned s, r;
    range_t res;
    p[0] = px; p[1] = py; p[2] = pz;
    dl2 = 0; dr2 = 0; dt2 = 0;
    for (int i = 0; i < 3; i++) t[i] = lane(trans_word, i);
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) acc += lane(rot_rows[i], j) * p[j];
      // Round half up to whole 1/16 mm; the arithmetic shift is a floor.
      q[i] = ((acc + (64'sd1 <<< 18)) >>> 19) + t[i];
    end
    for (int i = 0; i < 3; i++) begin
      dl2 += p[i] * p[i];
      dr2 += q[i] * q[i];
      dt2 += t[i] * t[i];
    end
    rad = 2 * dl2 + 2 * dr2 - dt2;
    if (rad < 0) rad = 0;
    s = int_root(longint'(unsigned'(rad)) << 8);
    r = (s * 16) / 125;
    res.sat = r > RANGE_MAX;
    res.meters = res.sat ? RANGE_MAX : r[RangeW-1:0];
    return res;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_ranges.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0d sat %0b",
                                       range_meters_o, range_saturated_o);
      end else begin
        range_t exp_r;
        exp_r = expected_ranges.pop_front();
        if (exp_r.meters !== range_meters_o || exp_r.sat !== range_saturated_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("range mismatch: expected %0d sat %0b, got %0d sat %0b",
                     exp_r.meters, exp_r.sat, range_meters_o, range_saturated_o);
        end
      end
    end
  end

  // Leaves start high after the transaction; the next call or caller lowers it.
  task automatic send_point(int x, int y, int z);
    int gap;
    logic signed [PointW-1:0] xs, ys, zs;
    range_t pred;
    xs = PointW'(x);
    ys = PointW'(y);
    zs = PointW'(z);
    gap = gaps_on ? $urandom_range(0, 8) : 0;
    repeat (gap) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i   <= 1'b1;
    point_x_i <= xs;
    point_y_i <= ys;
    point_z_i <= zs;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    pred = median_range(longint'(xs), longint'(ys), longint'(zs));
    expected_ranges.insert(expected_ranges.size(), pred);
  endtask

  task automatic drain;
    start_i <= 1'b0;
    @(posedge clk_i);
    while (expected_ranges.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes all registers; indexes past the last register must be ignored.
  task automatic load_regs(logic [RegW-1:0] r0, logic [RegW-1:0] r1,
                           logic [RegW-1:0] r2, logic [RegW-1:0] tr);
    logic [RegW-1:0] vals [4];
    vals[0] = r0; vals[1] = r1; vals[2] = r2; vals[3] = tr;
    drain();
    for (int i = 0; i < 4; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= i[IdxW-1:0];
      cfg_wdata_i <= vals[i];
      @(posedge clk_i);
    end
    for (int i = 4; i < 8; i++) begin
      cfg_idx_i   <= i[IdxW-1:0];
      cfg_wdata_i <= RegW'({$urandom, $urandom});
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    rot_rows[0] = r0; rot_rows[1] = r1; rot_rows[2] = r2; trans_word = tr;
  endtask

  function automatic logic [RegW-1:0] pack3(int a, int b, int c);
    return {c[LaneW-1:0], b[LaneW-1:0], a[LaneW-1:0]};
  endfunction

  function automatic logic [RegW-1:0] rand_reg;
    return RegW'({$urandom, $urandom});
  endfunction

  function automatic int rand_coord;
    case ($urandom_range(0, 3))
      0: return int'($signed(PointW'($urandom)));
      1: return int'($urandom_range(0, 4000)) - 2000;
      2: return $urandom_range(0, 1) ? CoordMax : CoordMin;
      default: return int'($urandom_range(0, 200000)) - 100000;
    endcase
  endfunction

  task automatic test_directed;
    gaps_on = 1'b1;
    send_point(0, 0, 0);
    send_point(CoordMax, CoordMax, CoordMax);
    send_point(CoordMin, CoordMin, CoordMin);
    send_point(CoordMax, CoordMin, 0);
    send_point(1, -1, 16000);
    // Near-double rotation makes the largest points saturate.
    load_regs(pack3(20'hFFFFF, 0, 0), pack3(0, 20'hFFFFF, 0), pack3(0, 0, 20'hFFFFF), 0);
    send_point(CoordMax, CoordMax, CoordMax);
    send_point(CoordMin, CoordMin, CoordMin);
    send_point(100, 200, 300);
    // Rotation of minus two with the point at half the translation cancels the
    // right-camera distance, so the radicand goes negative and clamps to zero.
    load_regs(pack3(-(1 << 20), 0, 0), pack3(0, -(1 << 20), 0), pack3(0, 0, -(1 << 20)),
              pack3(1000, -2000, 3000));
    send_point(500, -1000, 1500);
    send_point(0, 0, 0);
    send_point(CoordMax, 0, CoordMin);
    // Extreme lanes in the first two rotation rows and the translation; the last row is all ones.
    load_regs(pack3((1 << 20) - 1, -(1 << 20), (1 << 20) - 1),
              pack3(-(1 << 20), (1 << 20) - 1, -(1 << 20)),
              63'h7FFFFFFFFFFFFFFF,
              pack3((1 << 20) - 1, -(1 << 20), (1 << 20) - 1));
    send_point(CoordMax, CoordMin, CoordMax);
    send_point(CoordMin, CoordMax, CoordMin);
    send_point(0, 0, 0);
    send_point(-3, 7, 12345);
  endtask

  task automatic test_random_phase(logic [RegW-1:0] r0, logic [RegW-1:0] r1,
                                   logic [RegW-1:0] r2, logic [RegW-1:0] tr, int n);
    load_regs(r0, r1, r2, tr);
    for (int i = 0; i < n; i++) begin
      if (i % 60 == 0) gaps_on = $urandom_range(0, 3) != 0;
      send_point(rand_coord(), rand_coord(), rand_coord());
    end
  endtask

  task automatic test_random;
    int c, s;
    // A plausible stereo pose: small rotation about y and a short baseline.
    c = 524000; s = 17000;
    test_random_phase(pack3(c, 0, s), pack3(0, 1 << 19, 0), pack3(-s, 0, c),
                      pack3(-1920, 30, 5), 240);
    test_random_phase(rand_reg(), rand_reg(), rand_reg(), rand_reg(), 240);
    test_random_phase(rand_reg(), rand_reg(), rand_reg(), 0, 220);
    test_random_phase(63'h0, 63'h0, 63'h0, rand_reg(), 200);
    test_random_phase(ROT0_RESET, ROT1_RESET, ROT2_RESET, TRANS_RESET, 220);
    test_random_phase(rand_reg(), rand_reg(), rand_reg(), 63'h7FFFFFFFFFFFFFFF, 240);
  endtask

  initial begin
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    point_x_i   = '0;
    point_y_i   = '0;
    point_z_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = REG_ROT0;
    cfg_wdata_i = '0;
    mismatches  = 0;
    gaps_on     = 1'b1;
    rot_rows[0] = ROT0_RESET;
    rot_rows[1] = ROT1_RESET;
    rot_rows[2] = ROT2_RESET;
    trans_word  = TRANS_RESET;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random();
    start_i <= 1'b0;
    while (expected_ranges.size() != 0) @(posedge clk_i);
    repeat (Latency + 5) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("stereo_point_median_range_test: clean");
    end else begin
      $display("stereo_point_median_range_test: errors");
    end
    $finish;
  end

endmodule

>>> stereo_point_median_range.f
rtl/spmr_pkg.sv
rtl/stereo_point_median_range.sv
rtl/spmr_checker.sv
dv/stereo_point_median_range_test.sv
